### rtl/stmf_pkg.sv
// Shared constants and types for the spectrogram time median filter.
// Used by the core and by its port checker; depends on nothing else.

package stmf_pkg;

	// Default sizes of the history and of the stored values.
	localparam int DEF_MAX_WIDTH  = 16;
	localparam int DEF_MAX_BINS   = 512;
	localparam int DEF_VALUE_BITS = 32;

	// Field widths on the ports.
	localparam int MAGNITUDE_W    = 32;
	localparam int MEDIAN_W       = 32;
	localparam int BIN_INDEX_W    = 9;
	localparam int IN_TDATA_W     = 32;
	localparam int IN_TUSER_W     = 2;
	localparam int OUT_TDATA_W    = 48;
	localparam int OUT_PAD_W      = OUT_TDATA_W - MEDIAN_W - BIN_INDEX_W;

	// Bit positions in the input tuser.
	localparam int TUSER_PADDING  = 0;
	localparam int TUSER_START    = 1;

	// Configuration registers.
	localparam int WINDOW_WIDTH_W   = 5;
	localparam int BINS_PER_FRAME_W = 10;
	localparam int CFG_DATA_W       = 10;
	localparam int CFG_INDEX_W      = 1;

	localparam logic [WINDOW_WIDTH_W-1:0]   WINDOW_WIDTH_RST   = 5'd5;
	localparam logic [BINS_PER_FRAME_W-1:0] BINS_PER_FRAME_RST = 10'd512;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_WINDOW_WIDTH   = 1'b0,
		CFG_BINS_PER_FRAME = 1'b1
	} cfg_reg_t;

endpackage

### rtl/stmf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; used by the median filter core for the frame history.

module stmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/spectrogram_time_median_filter_core.sv
// Median filter along time for a spectrogram stream, with its frame history in one RAM.
// Depends on stmf_pkg and stmf_ram.
//
//  Channel | Direction | Handshake                  | Word
//  s_axis  | in        | s_axis_tvalid/tready       | tdata magnitude, tuser padding/start
//  m_axis  | out       | m_axis_tvalid/tready       | tdata median value, bin index
//  cfg     | in        | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// An item is merged with n - 1 stored frames, n = min(window width, frames seen + 1);
// the history RAM returns one stored frame per cycle.
// Stored frames are merged one per cycle into a sorted register row.
// Reset clears the counters and loads the default configuration; the history is not cleared.
// A result waits in the output register while the next input word is accepted; the block
// holds in its last step only if that register is still full.

module spectrogram_time_median_filter_core
	import stmf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_BINS   = DEF_MAX_BINS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] magnitude
	input  logic [IN_TUSER_W-1:0]   s_axis_tuser,  // [0] is_padding, [1] start_of_run
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata,  // [31:0] median_value, [40:32] bin_index
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int SLOT_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int SW        = SLOT_W + 1;
	localparam int BIN_W     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CNT_W     = $clog2(MAX_WIDTH + 2);
	localparam int ADDR_W    = SLOT_W + BIN_W;
	localparam int RAM_DEPTH = 1 << ADDR_W;
	localparam int MID_HI    = MAX_WIDTH / 2;
	localparam int MID_LO    = (MAX_WIDTH > 1) ? MAX_WIDTH / 2 - 1 : 0;
	localparam logic [CNT_W-1:0] HALF_ROW = CNT_W'(MAX_WIDTH / 2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [WINDOW_WIDTH_W-1:0]     window_width_q;
	logic [BINS_PER_FRAME_W-1:0]   bins_per_frame_q;
	logic [BIN_W-1:0]              bin_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [CNT_W-1:0]              frames_q;

	// Item registers, loaded at accept.
	logic [VALUE_BITS-1:0]         value_q;
	logic [BIN_W-1:0]              item_bin_q;
	logic [SLOT_W-1:0]             item_slot_q;
	logic [CNT_W-1:0]              n_q;
	logic                          w_odd_q;
	logic                          emit_q;

	logic                          ins_first_q;
	logic [CNT_W-1:0]              rd_d_q;
	logic [CNT_W-1:0]              ins_cnt_q;
	logic                          rd_vld_s1;
	logic [VALUE_BITS-1:0]         sort_q [MAX_WIDTH];
	logic [VALUE_BITS-1:0]         sort_nx [MAX_WIDTH];
	logic                          le [MAX_WIDTH];

	logic                          m_valid_q;
	logic [MEDIAN_W-1:0]           m_median_q;
	logic [BIN_INDEX_W-1:0]        m_bin_q;

	logic                          in_accept;
	logic                          start_run;
	logic [BIN_W-1:0]              bin_eff;
	logic [SLOT_W-1:0]             slot_eff;
	logic [CNT_W-1:0]              frames_eff;
	logic [CNT_W-1:0]              w_eff;
	logic [BIN_W:0]                bins_eff;
	logic [CNT_W-1:0]              frames_inc;
	logic [CNT_W-1:0]              n_eff;
	logic [CNT_W-1:0]              low_fill;
	logic [CNT_W-1:0]              lag;
	logic [VALUE_BITS-1:0]         value_in;
	logic [BIN_W:0]                bin_next;
	logic [SW-1:0]                 slot_inc;
	logic [SW-1:0]                 slot_sum;
	logic [SLOT_W-1:0]             slot_rd;
	logic                          rd_issue;
	logic                          ins_en;
	logic [VALUE_BITS-1:0]         ins_val;
	logic [VALUE_BITS-1:0]         rd_data;
	logic                          ins_last;
	logic                          out_free;
	logic                          out_load;
	logic [VALUE_BITS-1:0]         mid_hi;
	logic [VALUE_BITS-1:0]         mid_lo;
	logic [VALUE_BITS-1:0]         median;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_bin_q, m_median_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q   <= WINDOW_WIDTH_RST;
			bins_per_frame_q <= BINS_PER_FRAME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WINDOW_WIDTH:   window_width_q   <= cfg_data[WINDOW_WIDTH_W-1:0];
				CFG_BINS_PER_FRAME: bins_per_frame_q <= cfg_data[BINS_PER_FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	// A new run restarts the counters before the word is taken.
	assign start_run  = s_axis_tuser[TUSER_START];
	assign bin_eff    = start_run ? '0 : bin_q;
	assign slot_eff   = start_run ? '0 : slot_q;
	assign frames_eff = start_run ? '0 : frames_q;

	always_comb begin
		if (window_width_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (32'(window_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CNT_W'(MAX_WIDTH);
		end else begin
			w_eff = CNT_W'(window_width_q);
		end
		if (bins_per_frame_q == '0) begin
			bins_eff = (BIN_W + 1)'(1);
		end else if (32'(bins_per_frame_q) > 32'(MAX_BINS)) begin
			bins_eff = (BIN_W + 1)'(MAX_BINS);
		end else begin
			bins_eff = (BIN_W + 1)'(bins_per_frame_q);
		end
	end

	// Frames older than the run are zeros; they are not read but counted into the
	// low fill of the sorted row. The fill is chosen so that the median always lands
	// at the middle of the row.
	assign frames_inc = frames_eff + CNT_W'(1);
	assign n_eff      = (frames_inc < w_eff) ? frames_inc : w_eff;
	assign low_fill   = HALF_ROW - (w_eff >> 1) + (w_eff - n_eff);
	assign lag        = w_eff - CNT_W'(1) - (w_eff >> 1);
	assign value_in   = s_axis_tuser[TUSER_PADDING] ? '0
		: VALUE_BITS'(s_axis_tdata[MAGNITUDE_W-1:0]);
	assign bin_next   = (BIN_W + 1)'(bin_eff) + (BIN_W + 1)'(1);
	assign slot_inc   = SW'(slot_eff) + SW'(1);

	// Read address of the frame rd_d_q frames back, modulo the history depth.
	assign slot_sum = SW'(item_slot_q) + SW'(MAX_WIDTH) - SW'(rd_d_q);
	assign slot_rd  = (slot_sum >= SW'(MAX_WIDTH)) ? SLOT_W'(slot_sum - SW'(MAX_WIDTH))
		: SLOT_W'(slot_sum);
	assign rd_issue = (state_q == ST_RUN) && (rd_d_q < n_q);

	// The write at accept and the reads of one item never hit the same slot,
	// and all reads finish before the next accept.
	stmf_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (RAM_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (in_accept),
		.waddr ({slot_eff, bin_eff}),
		.wdata (value_in),
		.re    (rd_issue),
		.raddr ({slot_rd, item_bin_q}),
		.rdata (rd_data)
	);

	// Insertion into the ascending row; the top entry drops out.
	assign ins_en   = (state_q == ST_RUN) && (ins_first_q || rd_vld_s1);
	assign ins_val  = ins_first_q ? value_q : rd_data;
	assign ins_last = ins_en && (ins_cnt_q + CNT_W'(1) == n_q);

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_ins
		assign le[i] = (sort_q[i] <= ins_val);
		if (i == 0) begin : g_first
			assign sort_nx[i] = le[i] ? sort_q[i] : ins_val;
		end else begin : g_rest
			assign sort_nx[i] = le[i] ? sort_q[i] : (le[i-1] ? ins_val : sort_q[i-1]);
		end
	end

	assign mid_hi   = sort_q[MID_HI];
	assign mid_lo   = sort_q[MID_LO];
	assign median   = w_odd_q ? mid_hi
		: (mid_lo >> 1) + (mid_hi >> 1) + VALUE_BITS'(mid_lo[0] & mid_hi[0]);
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_DONE) && emit_q && out_free;

	// Item payload and sorted row.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			value_q     <= value_in;
			item_bin_q  <= bin_eff;
			item_slot_q <= slot_eff;
			n_q         <= n_eff;
			w_odd_q     <= w_eff[0];
			emit_q      <= (frames_eff >= lag);
			for (int i = 0; i < MAX_WIDTH; i++) begin
				sort_q[i] <= (CNT_W'(i) < low_fill) ? '0 : '1;
			end
		end else if (ins_en) begin
			sort_q <= sort_nx;
		end
	end

	// Sequencer, counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bin_q       <= '0;
			slot_q      <= '0;
			frames_q    <= '0;
			ins_first_q <= 1'b0;
			rd_d_q      <= '0;
			ins_cnt_q   <= '0;
			rd_vld_s1   <= 1'b0;
			m_valid_q   <= 1'b0;
			m_median_q  <= '0;
			m_bin_q     <= '0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q     <= ST_RUN;
						ins_first_q <= 1'b1;
						rd_d_q      <= CNT_W'(1);
						ins_cnt_q   <= '0;
						if (bin_next >= bins_eff) begin
							bin_q  <= '0;
							slot_q <= (slot_inc == SW'(MAX_WIDTH)) ? '0 : SLOT_W'(slot_inc);
							if (frames_eff < CNT_W'(MAX_WIDTH)) begin
								frames_q <= frames_eff + CNT_W'(1);
							end else begin
								frames_q <= frames_eff;
							end
						end else begin
							bin_q    <= BIN_W'(bin_next);
							slot_q   <= slot_eff;
							frames_q <= frames_eff;
						end
					end
				end
				ST_RUN: begin
					if (rd_issue) begin
						rd_d_q <= rd_d_q + CNT_W'(1);
					end
					if (ins_en) begin
						ins_first_q <= 1'b0;
						ins_cnt_q   <= ins_cnt_q + CNT_W'(1);
					end
					if (ins_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!emit_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_median_q <= MEDIAN_W'(median);
						m_bin_q    <= BIN_INDEX_W'(item_bin_q);
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/stmf_checker.sv
// Port-level checks for the spectrogram time median filter core, bound to its top level.
// Depends on stmf_pkg and on spectrogram_time_median_filter_core.

module stmf_checker
	import stmf_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_axis_tvalid,
	input logic                    s_axis_tready,
	input logic                    m_axis_tvalid,
	input logic                    m_axis_tready,
	input logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// The block works on one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a word is still in work");

	// A new result needs at least the merge and median steps after its word.
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready)
			&& !$past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result appeared too soon after an accepted word");

	// Fill bits above the bin index are zero.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:MEDIAN_W+BIN_INDEX_W] == '0)
		else $error("output fill bits not zero");

endmodule

bind spectrogram_time_median_filter_core stmf_checker u_stmf_checker (.*);
